>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        last_item;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		SRC_INPUT = 3'd0,
		SRC_PAD80 = 3'd1,
		SRC_ZERO  = 3'd2,
		SRC_LENHI = 3'd3,
		SRC_LENLO = 3'd4
	} word_src_t;

	typedef struct packed {
		logic      push;
		word_src_t src;
		logic      load_work;
		logic      round_en;
		logic      add_chain;
		logic      out_adv;
		logic      finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] pos;
		logic       round_last;
		logic       out_last;
	} dp_sts_t;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

>>> rtl/sha256_message_digest_unit.sv
// sha-256 digest over a stream of big-endian 32-bit message words
// input channel: in_valid/in_ready with in_data (message_word, valid_bytes,
// last_item); valid_bytes is read only on the final word, above four it counts as four
// output channel: out_valid/out_ready with out_data, eight transactions per
// message carrying digest words 0..7, last_word set on word 7
// a word that leaves its block open is taken while the unit stays idle; the
// word that fills a block is followed by the 64 compression rounds, run on the
// single shared round unit at one round per cycle, and one chaining add; in_ready
// is low throughout
// after the final word, padding words are written one per cycle outside the
// rounds, and one or two more blocks are compressed, then the digest is offered;
// in_ready stays low until the eighth digest word is taken
// how long out_valid waits after the final word is taken is set by where
// the final word lands in its block
// a stall on out_ready holds the current digest word steady and nothing is lost
// after the last digest word the chaining value returns to the initial hash
// and the length count to zero, ready for the next message
// reset puts the unit idle with the initial hash, empty block and zero length
`timescale 1ns / 1ps
module sha256_message_digest_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha256_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_data
);
	import sha256_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sha256_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

>>> rtl/sha256_ctrl.sv
`timescale 1ns / 1ps
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sha256_pkg::in_item_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sha256_pkg::dp_cmd_t  cmd,
	input  sha256_pkg::dp_sts_t  sts
);
	import sha256_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_ADD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		PH_NONE  = 5'b00001,
		PH_PAD80 = 5'b00010,
		PH_ZERO  = 5'b00100,
		PH_LENLO = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_NONE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cmd       = '0;
		cmd.src   = SRC_INPUT;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.push = 1'b1;
					if (in_data.last_item) begin
						phase_d = in_data.valid_bytes[2] ? PH_PAD80 : PH_ZERO;
					end
					if (sts.pos == 4'd15) begin
						cmd.load_work = 1'b1;
						state_d       = S_ROUND;
					end else if (in_data.last_item) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.push = 1'b1;
				case (phase_q)
					PH_PAD80: begin
						cmd.src = SRC_PAD80;
						phase_d = PH_ZERO;
					end
					PH_ZERO: begin
						if (sts.pos == 4'd14) begin
							cmd.src = SRC_LENHI;
							phase_d = PH_LENLO;
						end else begin
							cmd.src = SRC_ZERO;
						end
					end
					PH_LENLO: begin
						cmd.src = SRC_LENLO;
						phase_d = PH_DONE;
					end
					default: begin
						cmd.push = 1'b0;
					end
				endcase
				if (cmd.push && sts.pos == 4'd15) begin
					cmd.load_work = 1'b1;
					state_d       = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				if (sts.round_last) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add_chain = 1'b1;
				case (phase_q)
					PH_NONE: state_d = S_IDLE;
					PH_DONE: state_d = S_OUT;
					default: state_d = S_PAD;
				endcase
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_adv = 1'b1;
					if (sts.out_last) begin
						cmd.finish = 1'b1;
						phase_d    = PH_NONE;
						state_d    = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
				phase_d = PH_NONE;
			end
		endcase
	end

endmodule

>>> rtl/sha256_dp.sv
`timescale 1ns / 1ps
module sha256_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::in_item_t  in_data,
	input  sha256_pkg::dp_cmd_t   cmd,
	output sha256_pkg::dp_sts_t   sts,
	output sha256_pkg::out_item_t out_data
);
	import sha256_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] chain_q [8];
	logic [31:0] work_q [8];
	logic [31:0] sched_q [16];
	logic [3:0]  pos_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_idx_q;

	logic [2:0]  cnt;
	logic [31:0] keep;
	logic [31:0] in_word;
	logic [31:0] push_word;
	logic [5:0]  len_inc;
	logic [31:0] s0, s1, w_new;
	logic [31:0] t1, t2;

	// final word byte count, saturated at four
	assign cnt = in_data.valid_bytes[2] ? 3'd4 : in_data.valid_bytes;

	always_comb begin
		case (cnt)
			3'd0:    keep = 32'h0000_0000;
			3'd1:    keep = 32'hff00_0000;
			3'd2:    keep = 32'hffff_0000;
			3'd3:    keep = 32'hffff_ff00;
			default: keep = 32'hffff_ffff;
		endcase
	end

	always_comb begin
		if (!in_data.last_item || cnt == 3'd4) begin
			in_word = in_data.message_word & keep;
			if (!in_data.last_item) begin
				in_word = in_data.message_word;
			end
		end else begin
			in_word = (in_data.message_word & keep) | (PAD_WORD >> {cnt[1:0], 3'b000});
		end
	end

	always_comb begin
		case (cmd.src)
			SRC_INPUT: push_word = in_word;
			SRC_PAD80: push_word = PAD_WORD;
			SRC_LENHI: push_word = len_q[63:32];
			SRC_LENLO: push_word = len_q[31:0];
			default:   push_word = '0;
		endcase
	end

	assign len_inc = in_data.last_item ? {cnt, 3'b000} : 6'd32;

	// message schedule from the sliding sixteen-word window
	assign s0    = rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3);
	assign s1    = rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10);
	assign w_new = s1 + sched_q[9] + s0 + sched_q[0];

	assign t1 = work_q[7]
		+ (rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25))
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ ROUND_K[rnd_q] + sched_q[0];
	assign t2 = (rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22))
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			sched_q[pos_q] <= push_word;
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			work_q <= chain_q;
		end else if (cmd.round_en) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q   <= INIT_HASH;
			pos_q     <= '0;
			len_q     <= '0;
			rnd_q     <= '0;
			out_idx_q <= '0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 4'd1;
			end
			if (cmd.push && cmd.src == SRC_INPUT) begin
				len_q <= len_q + {58'd0, len_inc};
			end
			if (cmd.load_work) begin
				rnd_q <= '0;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.add_chain) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (cmd.out_adv) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
			if (cmd.finish) begin
				chain_q <= INIT_HASH;
				len_q   <= '0;
			end
		end
	end

	assign sts.pos        = pos_q;
	assign sts.round_last = (rnd_q == 6'd63);
	assign sts.out_last   = (out_idx_q == 3'd7);

	assign out_data.digest_word = chain_q[out_idx_q];
	assign out_data.word_index  = out_idx_q;
	assign out_data.last_word   = (out_idx_q == 3'd7);

endmodule

>>> rtl/sha256_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input sha256_pkg::in_item_t  in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input sha256_pkg::out_item_t out_data
);
	import sha256_pkg::*;

	`ASSERT_SAME(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input taken while digest pending")
	`ASSERT_SAME(a_last_flag, clk, arst_n, out_valid, out_data.last_word == (out_data.word_index == 3'd7), "last_word mismatch")
	`ASSERT_NEXT(a_index_step, clk, arst_n, out_valid && out_ready && !out_data.last_word, out_valid && out_data.word_index == 3'($past(out_data.word_index) + 3'd1), "digest word skipped")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "digest changed under stall")
	`ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_data), "input changed while waiting")

endmodule

bind sha256_message_digest_unit sha256_checker u_sha256_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
